@@ design/gcd_pkg.sv @@
package gcd_pkg;

    // Operand width of the arithmetic; the stream fields stay at 32 bits.
    localparam int OPERAND_WIDTH = 32;
    localparam int FIELD_WIDTH   = 32;
    localparam int K_WIDTH       = $clog2(OPERAND_WIDTH + 1);
    localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);
    localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;

    // Action codes carried in the input tuser.
    localparam logic ACT_GCD = 1'b0;
    localparam logic ACT_LCM = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic gcd_step;
        logic gcd_fin;
        logic div_init;
        logic div_step;
        logic mul;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gcd_done;
        logic both_zero;
        logic is_lcm;
        logic div_last;
    } t_dp_sts;

endpackage

@@ design/gcd_datapath.sv @@
module gcd_datapath
    import gcd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_act,
    input  logic [FIELD_WIDTH-1:0] i_first,
    input  logic [FIELD_WIDTH-1:0] i_second,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    output logic [FIELD_WIDTH-1:0] o_answer,
    output logic                   o_overflow
);

    localparam int W = OPERAND_WIDTH;

    logic                 r_act;
    logic [W-1:0]         r_a;
    logic [W-1:0]         r_b;
    logic [W-1:0]         r_x;
    logic [W-1:0]         r_y;
    logic [K_WIDTH-1:0]   r_k;
    logic [W-1:0]         r_g;
    logic [W-1:0]         r_rem;
    logic [W-1:0]         r_quo;
    logic [CNT_WIDTH-1:0] r_cnt;
    logic [PROD_WIDTH-1:0] r_prod;
    logic [FIELD_WIDTH-1:0] r_answer;
    logic                 r_overflow;

    logic [W-1:0]         n_x;
    logic [W-1:0]         n_y;
    logic [K_WIDTH-1:0]   n_k;
    logic [W:0]           trial;
    logic [W:0]           trial_diff;
    logic                 trial_ok;
    logic [W-1:0]         x_minus_y;
    logic [W-1:0]         y_minus_x;

    assign x_minus_y = r_x - r_y;
    assign y_minus_x = r_y - r_x;

    // One binary GCD step: strip common twos, strip single twos, or subtract and halve.
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_k = r_k;
        priority if (!r_x[0] && !r_y[0]) begin
            n_x = r_x >> 1;
            n_y = r_y >> 1;
            n_k = r_k + K_WIDTH'(1);
        end else if (!r_x[0]) begin
            n_x = r_x >> 1;
        end else if (!r_y[0]) begin
            n_y = r_y >> 1;
        end else if (r_x >= r_y) begin
            n_x = x_minus_y >> 1;
        end else begin
            n_y = y_minus_x >> 1;
        end
    end

    // Restoring divide: one quotient bit per cycle.
    assign trial      = {r_rem, r_quo[W-1]};
    assign trial_diff = trial - {1'b0, r_g};
    assign trial_ok   = !trial_diff[W];

    // Operand and GCD registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_act;
            r_a   <= W'(i_first);
            r_b   <= W'(i_second);
            r_x   <= W'(i_first);
            r_y   <= W'(i_second);
            r_k   <= '0;
        end else if (i_cmd.gcd_step) begin
            r_x <= n_x;
            r_y <= n_y;
            r_k <= n_k;
        end
        if (i_cmd.gcd_fin) begin
            // One of the two is zero here, so the OR picks the other.
            r_g <= (r_x | r_y) << r_k;
        end
    end

    // Divider registers for first / gcd.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= r_a;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ok ? trial_diff[W-1:0] : trial[W-1:0];
            r_quo <= {r_quo[W-2:0], trial_ok};
            r_cnt <= r_cnt + CNT_WIDTH'(1);
        end
    end

    // Product of quotient and second operand; with both operands zero it is zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= o_sts.both_zero ? '0 : r_quo * r_b;
        end
    end

    // Result register holds the answer while a new request is worked on.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_act == ACT_LCM) begin
                r_answer   <= FIELD_WIDTH'(r_prod[W-1:0]);
                r_overflow <= |r_prod[PROD_WIDTH-1:W];
            end else begin
                r_answer   <= FIELD_WIDTH'(r_g);
                r_overflow <= 1'b0;
            end
        end
    end

    assign o_sts.gcd_done  = (r_x == '0) || (r_y == '0);
    assign o_sts.both_zero = (r_a == '0) && (r_b == '0);
    assign o_sts.is_lcm    = (r_act == ACT_LCM);
    assign o_sts.div_last  = (r_cnt == CNT_WIDTH'(W - 1));
    assign o_answer        = r_answer;
    assign o_overflow      = r_overflow;

endmodule

@@ design/gcd_control.sv @@
module gcd_control
    import gcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // State and output-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                if (i_sts.gcd_done) begin
                    if (!i_sts.is_lcm) begin
                        n_state = ST_DONE;
                    end else if (i_sts.both_zero) begin
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath commands and handshake outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_GCD: begin
                o_cmd.gcd_step = !i_sts.gcd_done;
                o_cmd.gcd_fin  = i_sts.gcd_done;
                o_cmd.div_init = i_sts.gcd_done;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_DONE: begin
                o_cmd.emit = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // The result flag rises on emit and falls when the result is taken.
    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ design/gcd_lcm_unit.sv @@
// Channel  | Ports                  | Contents (lowest bit first)
// ---------+------------------------+------------------------------------------
// input    | i_s_tvalid/o_s_tready  | tdata: first_operand, second_operand
//          |                        | tuser: action (0 gcd, 1 lcm)
// output   | o_m_tvalid/i_m_tready  | tdata: answer; tuser: overflow
//
// The binary GCD loop and, for lcm, the one bit per cycle restoring divider set how
// long a request takes; the product is one registered multiply.
// Reset clears the controller and the result valid flag only.
// A new request is taken while the previous result still waits on i_m_tready;
// a finished result holds in its state until the output register is free.
module gcd_lcm_unit
    import gcd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [2*FIELD_WIDTH-1:0]   i_s_tdata,   // first_operand, second_operand
    input  logic                       i_s_tuser,   // action
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [FIELD_WIDTH-1:0]     o_m_tdata,   // answer
    output logic                       o_m_tuser    // overflow
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    gcd_control u_control (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_out_ready (i_m_tready),
        .i_sts       (sts),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .o_cmd       (cmd)
    );

    // Arithmetic and result register.
    gcd_datapath u_datapath (
        .i_clk      (i_clk),
        .i_act      (i_s_tuser),
        .i_first    (i_s_tdata[FIELD_WIDTH-1:0]),
        .i_second   (i_s_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH]),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_answer   (o_m_tdata),
        .o_overflow (o_m_tuser)
    );

endmodule

@@ dv/gcd_lcm_checker.sv @@
`timescale 1ns / 100ps

// Watches both stream channels of gcd_lcm_unit. Every accepted request is
// turned into an expected answer, and every accepted result is compared with
// the oldest answer still waiting.
module gcd_lcm_checker
    import gcd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    input  logic                     i_s_tready,
    input  logic [2*FIELD_WIDTH-1:0] i_s_tdata,   // first_operand, second_operand
    input  logic                     i_s_tuser,   // action
    input  logic                     i_m_tvalid,
    input  logic                     i_m_tready,
    input  logic [FIELD_WIDTH-1:0]   i_m_tdata,   // answer
    input  logic                     i_m_tuser,   // overflow
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct {
        logic [FIELD_WIDTH-1:0] answer;
        logic                   overflow;
    } t_answer;

    t_answer expected_answers[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Euclid's remainder loop, then the lcm as (first / gcd) * second with the
    // product checked against the operand width.
    function automatic t_answer calc_gcd_lcm(logic act, logic [FIELD_WIDTH-1:0] first,
                                             logic [FIELD_WIDTH-1:0] second);
        logic [63:0]  mask;
        logic [63:0]  x;
        logic [63:0]  y;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  rem;
        logic [63:0]  quot;
        logic [63:0]  value;
        logic [127:0] product;
        t_answer      res;
        mask = (OPERAND_WIDTH >= 64) ? '1 : ((64'd1 << OPERAND_WIDTH) - 64'd1);
        a = 64'(first) & mask;
        b = 64'(second) & mask;
        x = a;
        y = b;
        while (y != 64'd0) begin
            rem = x % y;
            x   = y;
            y   = rem;
        end
        res.overflow = 1'b0;
        if (act == ACT_GCD) begin
            value = x;
        end else if (x == 64'd0) begin
            // Both operands zero: no divide, the lcm is simply zero.
            value = 64'd0;
        end else begin
            quot         = a / x;
            product      = 128'(quot) * 128'(b);
            res.overflow = product > 128'(mask);
            value        = product[63:0] & mask;
        end
        res.answer = value[FIELD_WIDTH-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    // Results are handled before requests: a request accepted at this edge
    // cannot already have produced the result seen at the same edge.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch($sformatf("unexpected result answer=%0d overflow=%0b",
                                              i_m_tdata, i_m_tuser));
                end else begin
                    want = expected_answers.pop_front();
                    if (i_m_tdata !== want.answer)
                        report_mismatch($sformatf("answer %0d, expected %0d",
                                                  i_m_tdata, want.answer));
                    if (i_m_tuser !== want.overflow)
                        report_mismatch($sformatf("overflow %0b, expected %0b (answer %0d)",
                                                  i_m_tuser, want.overflow, want.answer));
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_answers.push_back(calc_gcd_lcm(i_s_tuser,
                                                        i_s_tdata[FIELD_WIDTH-1:0],
                                                        i_s_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH]));
            o_pending = expected_answers.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import gcd_pkg::*;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [2*FIELD_WIDTH-1:0] s_tdata = '0;   // first_operand, second_operand
    logic                     s_tuser = ACT_GCD;   // action
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [FIELD_WIDTH-1:0]   m_tdata;   // answer
    logic                     m_tuser;   // overflow

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    gcd_lcm_unit u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    gcd_lcm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: a long hold-off when one is requested, random idling otherwise.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one request after a random gap and waits until it is taken.
    task automatic send_request(logic act, logic [FIELD_WIDTH-1:0] first,
                                logic [FIELD_WIDTH-1:0] second);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {second, first};
        s_tuser  <= act;
        do @(posedge clk); while (!s_tready);
    endtask

    // Mixes operand shapes so that gcd results other than one, zero operands
    // and both sides of the lcm overflow boundary all come up often.
    task automatic send_random_requests(int count);
        logic [FIELD_WIDTH-1:0] first;
        logic [FIELD_WIDTH-1:0] second;
        logic [FIELD_WIDTH-1:0] factor;
        logic                   act;
        repeat (count) begin
            act = $urandom_range(1) ? ACT_LCM : ACT_GCD;
            case ($urandom_range(5))
                0: begin
                    first  = $urandom;
                    second = $urandom;
                end
                1, 2: begin
                    factor = $urandom_range(1, 65536);
                    first  = factor * $urandom_range(0, 32'hFFFF_FFFF / factor);
                    second = factor * $urandom_range(0, 32'hFFFF_FFFF / factor);
                end
                3: begin
                    // Products near 2**32 land on either side of the overflow limit.
                    first  = $urandom_range(1, 131071);
                    second = $urandom_range(1, 131071);
                end
                4: begin
                    first  = $urandom_range(0, 255);
                    second = $urandom_range(0, 255);
                end
                default: begin
                    first  = $urandom;
                    case ($urandom_range(3))
                        0: second = 32'd0;
                        1: second = first;
                        2: second = 32'd1;
                        default: second = 32'd1 << $urandom_range(31);
                    endcase
                    if ($urandom_range(1))
                        {first, second} = {second, first};
                end
            endcase
            send_request(act, first, second);
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 82;

        // Zero operands, for both actions.
        send_request(ACT_GCD, 32'd0, 32'd0);
        send_request(ACT_LCM, 32'd0, 32'd0);
        send_request(ACT_GCD, 32'd12345, 32'd0);
        send_request(ACT_GCD, 32'd0, 32'hFFFF_FFFF);
        send_request(ACT_LCM, 32'hFFFF_FFFF, 32'd0);
        send_request(ACT_LCM, 32'd0, 32'd98765);
        // Full-scale operands.
        send_request(ACT_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_request(ACT_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_request(ACT_LCM, 32'd1, 32'hFFFF_FFFF);
        send_request(ACT_LCM, 32'hFFFF_FFFF, 32'd1);
        // Consecutive Fibonacci numbers: the longest remainder chain.
        send_request(ACT_GCD, 32'd2971215073, 32'd1836311903);
        send_request(ACT_LCM, 32'd1836311903, 32'd2971215073);
        // Powers of two.
        send_request(ACT_GCD, 32'h8000_0000, 32'h4000_0000);
        send_request(ACT_LCM, 32'h8000_0000, 32'h4000_0000);
        send_request(ACT_LCM, 32'h8000_0000, 32'd3);
        // Just fits and just overflows 32 bits.
        send_request(ACT_LCM, 32'd65535, 32'd65537);
        send_request(ACT_LCM, 32'd65536, 32'd65537);
        send_request(ACT_LCM, 32'd65536, 32'd65536);
        send_request(ACT_GCD, 32'd1, 32'd1);
        send_request(ACT_LCM, 32'd21, 32'd6);
        send_request(ACT_GCD, 32'hAAAA_AAAA, 32'h5555_5555);

        send_random_requests(560);

        send_idle_pct = 82;
        recv_idle_pct = 33;
        send_random_requests(560);

        // No idling; a long result stall first fills the block and blocks requests.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 600;
        send_random_requests(560);

        @(negedge clk);
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (150) @(negedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("gcd_lcm_unit verification clean");
        end else begin
            $display("gcd_lcm_unit verification failed");
        end
        $finish;
    end

    // Watchdog, several times the slowest expected run.
    initial begin
        #3_000_000;
        $display("gcd_lcm_unit verification failed");
        $finish;
    end

endmodule

@@ files.f @@
design/gcd_pkg.sv
design/gcd_datapath.sv
design/gcd_control.sv
design/gcd_lcm_unit.sv
dv/gcd_lcm_checker.sv
dv/tb_top.sv
